@@ src/fpvt_pkg.sv @@
// shared types and constants for the fixed-point 4x4 vertex transform
`default_nettype none

package fpvt_pkg;

    localparam int DIM       = 4;
    localparam int WORD_W    = 32;
    localparam int IDX_W     = 4;
    localparam int S_DATA_W  = 168;
    localparam int M_DATA_W  = DIM * WORD_W;

    typedef logic [WORD_W-1:0] word_t;
    typedef logic [DIM-1:0][WORD_W-1:0] vec_t;
    typedef logic [DIM-1:0][DIM-1:0][WORD_W-1:0] mat_t;

    typedef enum logic {
        CMD_LOAD  = 1'b0,
        CMD_XFORM = 1'b1
    } cmd_t;

endpackage

`default_nettype wire

@@ src/fixed_point_vertex_transform_4x4.sv @@
// top level of the fixed-point 4x4 matrix times vector transform
//
// requests arrive on the s_ stream; s_tuser selects the kind of request.
// a load request (CMD_LOAD) writes one signed matrix element at elem_index
// (row*4 + column) and gives no result. a transform request (CMD_XFORM)
// multiplies the held matrix by the carried vector and gives one result on
// the m_ stream holding the four row dot products.
// each product is formed at 64 bits, shifted right arithmetically by
// FRAC_BITS and cut to 32 bits; row sums wrap at 32 bits.
// a request passes through the input register, multiply stage, pair add
// stage, and final add and output register on its way to the result.
// one request is taken per cycle unless the output stalls; sixteen
// multipliers, one per matrix element, work in parallel in the multiply stage.
// a transform sees every load accepted before it and none after it.
// reset clears the matrix to zero and empties the pipeline.
// when the receiver stalls with a result waiting, the whole pipeline holds
// and s_tready drops; nothing is lost or repeated.
`default_nettype none

module fixed_point_vertex_transform_4x4
    import fpvt_pkg::*;
#(
    parameter int FRAC_BITS = 8
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    // elem_index, elem_value, vec_x, vec_y, vec_z, vec_w, zero pad
    input  wire logic [S_DATA_W-1:0]   s_tdata,
    // cmd
    input  wire logic [0:0]            s_tuser,
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    // out_x, out_y, out_z, out_w
    output logic [M_DATA_W-1:0]        m_tdata
);

    logic [IDX_W-1:0] elem_index;
    word_t            elem_value;
    vec_t             s_vec;
    logic             en;
    logic             s_fire;

    mat_t             mat_reg, mat_next;
    vec_t             vec_reg;
    logic [3:0]       valid_reg, valid_next;
    vec_t             row_sum;

    assign elem_index = s_tdata[IDX_W-1:0];
    assign elem_value = s_tdata[IDX_W +: WORD_W];
    always_comb begin
        for (int c = 0; c < DIM; c++) begin
            s_vec[c] = s_tdata[IDX_W + WORD_W*(c+1) +: WORD_W];
        end
    end

    assign en       = !valid_reg[3] || m_tready;
    assign s_tready = en;
    assign s_fire   = s_tvalid && en;

    always_comb begin
        mat_next = mat_reg;
        if (s_fire && (s_tuser[0] == CMD_LOAD)) begin
            mat_next[elem_index[3:2]][elem_index[1:0]] = elem_value;
        end
        valid_next = valid_reg;
        if (en) begin
            valid_next = {valid_reg[2:0], s_fire && (s_tuser[0] == CMD_XFORM)};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mat_reg   <= '0;
            valid_reg <= '0;
        end else begin
            mat_reg   <= mat_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            vec_reg <= s_vec;
        end
    end

    for (genvar r = 0; r < DIM; r++) begin : g_row
        fpvt_dot4 #(
            .FRAC_BITS (FRAC_BITS)
        ) u_dot4 (
            .aclk (aclk),
            .en   (en),
            .row  (mat_reg[r]),
            .vec  (vec_reg),
            .sum  (row_sum[r])
        );
    end

    assign m_tvalid = valid_reg[3];
    assign m_tdata  = row_sum;

endmodule

`default_nettype wire

@@ src/fpvt_dot4.sv @@
// one matrix row times the vector: multiply, pair add and final add stages
`default_nettype none

module fpvt_dot4
    import fpvt_pkg::*;
#(
    parameter int FRAC_BITS = 8
) (
    input  wire logic  aclk,
    input  wire logic  en,
    input  wire vec_t  row,
    input  wire vec_t  vec,
    output word_t      sum
);

    word_t [DIM-1:0]   prod_reg;
    word_t [DIM/2-1:0] pair_reg;
    word_t             sum_reg;

    logic signed [2*WORD_W-1:0] full [DIM];

    always_comb begin
        for (int c = 0; c < DIM; c++) begin
            full[c] = $signed(row[c]) * $signed(vec[c]);
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int c = 0; c < DIM; c++) begin
                prod_reg[c] <= full[c][FRAC_BITS +: WORD_W];
            end
            for (int p = 0; p < DIM/2; p++) begin
                pair_reg[p] <= prod_reg[2*p] + prod_reg[2*p+1];
            end
            sum_reg <= pair_reg[0] + pair_reg[1];
        end
    end

    assign sum = sum_reg;

endmodule

`default_nettype wire

@@ src/fpvt_checker.sv @@
// port-level checks for the vertex transform and their binding
`default_nettype none

module fpvt_checker
    import fpvt_pkg::*;
(
    input wire logic                aclk,
    input wire logic                aresetn,
    input wire logic                s_tready,
    input wire logic                m_tvalid,
    input wire logic                m_tready,
    input wire logic [M_DATA_W-1:0] m_tdata
);

    // held result stays put
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // result leaves only when taken
    a_drop: assert property (@(posedge aclk) disable iff (!aresetn)
        $fell(m_tvalid) |-> $past(m_tready))
        else $error("result dropped without handshake");

    // empty output never blocks requests
    a_free: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("request blocked with empty output");

    // stalled result holds back requests
    a_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |-> !s_tready)
        else $error("request taken while output stalled");

endmodule

bind fixed_point_vertex_transform_4x4 fpvt_checker u_fpvt_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire

@@ tb/tb_fixed_point_vertex_transform_4x4.sv @@
// self-checking testbench for the fixed-point 4x4 matrix times vector transform
`timescale 1ns / 100ps

module tb_fixed_point_vertex_transform_4x4;
    import fpvt_pkg::*;

    localparam int FRAC_BITS = 8;
    localparam int VAL_LSB   = IDX_W;
    localparam int VEC_LSB   = IDX_W + WORD_W;
    localparam int PAD_W     = S_DATA_W - IDX_W - 5 * WORD_W;
    localparam int STALL_PCT = 24;
    localparam int SHOWN_MAX = 10;
    localparam int WATCHDOG  = 2000;
    localparam int N_RANDOM  = 1300;
    localparam word_t W_MAX  = 32'h7FFF_FFFF;
    localparam word_t W_MIN  = 32'h8000_0000;
    localparam word_t W_NEG1 = 32'hFFFF_FFFF;
    localparam word_t W_ONE  = 32'h0000_0001;
    localparam word_t W_UNIT = 32'h1 << FRAC_BITS;

    typedef struct {
        cmd_t             cmd;
        logic [IDX_W-1:0] idx;
        word_t            value;
        vec_t             vec;
    } request_t;

    logic                aclk     = 1'b0;
    logic                aresetn  = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata  = '0;
    logic [0:0]          s_tuser  = '0;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [M_DATA_W-1:0] m_tdata;

    request_t pending_requests[$];
    vec_t     expected_vertices[$];
    word_t    matrix_copy[DIM*DIM];
    request_t next_req;
    vec_t     want;
    bit       s_hs   = 1'b0;
    bit       m_hs   = 1'b0;
    bit       calm   = 1'b0;
    int       cyc    = 0;
    int       quiet  = 0;
    int       errors = 0;
    int       row;

    fixed_point_vertex_transform_4x4 #(
        .FRAC_BITS(FRAC_BITS)
    ) uut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata)
    );

    always #10 aclk = ~aclk;

    function automatic word_t fixed_mul(input word_t a, input word_t b);
        logic signed [63:0] prod;
        prod = $signed({{32{a[31]}}, a}) * $signed({{32{b[31]}}, b});
        prod = prod >>> FRAC_BITS;
        return prod[31:0];
    endfunction

    function automatic vec_t transform_vertex(input vec_t v);
        vec_t res;
        res = '0;
        for (int r = 0; r < DIM; r++) begin
            for (int c = 0; c < DIM; c++) begin
                res[r] = res[r] + fixed_mul(matrix_copy[r*DIM + c], v[c]);
            end
        end
        return res;
    endfunction

    function automatic word_t pick_fixed_value();
        word_t extremes[4];
        extremes = '{W_MAX, W_MIN, W_NEG1, 32'h0};
        case ($urandom_range(5))
            0: return extremes[$urandom_range(3)];
            1: return word_t'($urandom_range(2047)) - 32'd1024;
            2: return (word_t'($urandom_range(8)) - 32'd4) << FRAC_BITS;
            default: return $urandom();
        endcase
    endfunction

    task automatic add_load(input logic [IDX_W-1:0] idx, input word_t value);
        request_t r;
        r.cmd   = CMD_LOAD;
        r.idx   = idx;
        r.value = value;
        r.vec   = {$urandom(), $urandom(), $urandom(), $urandom()};
        pending_requests.push_back(r);
    endtask

    task automatic add_transform(input word_t x, input word_t y, input word_t z, input word_t w);
        request_t r;
        r.cmd   = CMD_XFORM;
        r.idx   = IDX_W'($urandom());
        r.value = $urandom();
        r.vec   = {w, z, y, x};
        pending_requests.push_back(r);
    endtask

    // driver: requests and result back-pressure change on the falling edge
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            m_tready <= 1'b0;
        end else begin
            if (!s_tvalid || s_hs) begin
                if (pending_requests.size() > 0 && (calm || $urandom_range(99) >= STALL_PCT)) begin
                    next_req = pending_requests.pop_front();
                    s_tvalid <= 1'b1;
                    s_tuser  <= next_req.cmd;
                    s_tdata  <= {{PAD_W{1'b0}}, next_req.vec, next_req.value, next_req.idx};
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
            m_tready <= calm || ($urandom_range(99) >= STALL_PCT);
        end
    end

    // monitor, predictor and watchdog, all sampled on the rising edge
    always @(posedge aclk) begin
        cyc  = cyc + 1;
        calm = (cyc >= 500 && cyc < 900);
        s_hs = aresetn && s_tvalid && s_tready;
        m_hs = aresetn && m_tvalid && m_tready;

        if (m_hs) begin
            if (expected_vertices.size() == 0) begin
                errors++;
                if (errors <= SHOWN_MAX)
                    $display("unexpected result %h at cycle %0d", m_tdata, cyc);
            end else begin
                want = expected_vertices.pop_front();
                for (row = 0; row < DIM; row++) begin
                    if (m_tdata[row*WORD_W +: WORD_W] !== want[row]) begin
                        errors++;
                        if (errors <= SHOWN_MAX)
                            $display("row %0d mismatch at cycle %0d: expected %h, got %h",
                                     row, cyc, want[row], m_tdata[row*WORD_W +: WORD_W]);
                    end
                end
            end
        end

        if (s_hs) begin
            if (cmd_t'(s_tuser) == CMD_LOAD)
                matrix_copy[s_tdata[IDX_W-1:0]] = s_tdata[VAL_LSB +: WORD_W];
            else
                expected_vertices.push_back(transform_vertex(s_tdata[VEC_LSB +: 4*WORD_W]));
        end

        if (s_hs || m_hs) begin
            quiet = 0;
        end else begin
            quiet = quiet + 1;
            if (quiet >= WATCHDOG) begin
                $display("FAIL");
                $finish;
            end
        end
    end

    initial begin
        int n;
        int kind;
        for (int i = 0; i < DIM*DIM; i++) matrix_copy[i] = '0;

        // matrix still clear after reset
        add_transform(W_MAX, W_MIN, W_NEG1, W_ONE);
        add_load(4'd0, W_MAX);
        add_load(4'd1, W_MIN);
        add_load(4'd6, W_NEG1);
        add_load(4'd15, W_UNIT);
        add_load(4'd9, W_ONE);
        add_transform(W_MIN, W_MAX, W_NEG1, W_UNIT);
        add_transform(W_MAX, W_MAX, W_MAX, W_MAX);
        // wrap of the shifted product
        add_transform(W_MIN, W_MIN, W_MIN, W_MIN);
        // truncation toward minus infinity
        add_transform(W_NEG1, W_NEG1, W_NEG1, W_NEG1);
        add_transform(W_ONE, W_ONE, W_ONE, W_ONE);
        add_load(4'd15, W_MIN);
        add_transform(32'h0, 32'h0, 32'h0, W_NEG1);

        n = 0;
        while (n < N_RANDOM) begin
            kind = $urandom_range(99);
            if (kind < 8) begin
                // whole new matrix followed by a burst of vertices
                for (int i = 0; i < DIM*DIM; i++) add_load(IDX_W'(i), pick_fixed_value());
                for (int i = 0; i < 6; i++)
                    add_transform(pick_fixed_value(), pick_fixed_value(),
                                  pick_fixed_value(), pick_fixed_value());
                n = n + 22;
            end else if (kind < 25) begin
                add_load(IDX_W'($urandom()), pick_fixed_value());
                n = n + 1;
            end else begin
                add_transform(pick_fixed_value(), pick_fixed_value(),
                              pick_fixed_value(), pick_fixed_value());
                n = n + 1;
            end
        end

        repeat (10) @(negedge aclk);
        aresetn <= 1'b1;

        while (pending_requests.size() > 0 || s_tvalid || expected_vertices.size() > 0)
            @(posedge aclk);
        repeat (12) @(posedge aclk);

        if (errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
